// ===== hdl/fade_envelope_sequencer_top_defines.svh =====
// assertion helpers shared by the checker file
`ifndef FADE_ENVELOPE_SEQUENCER_TOP_DEFINES_SVH
`define FADE_ENVELOPE_SEQUENCER_TOP_DEFINES_SVH

// condition and consequence in the same cycle
`define FES_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("fade envelope sequencer check failed");

// consequence in the cycle after the condition
`define FES_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fade envelope sequencer check failed");

`endif

// ===== hdl/fes_pkg.sv =====
`default_nettype none

package fes_pkg;

  localparam int unsigned DURATION_BITS = 16;
  localparam int unsigned ELAPSED_BITS  = 20;
  localparam int unsigned DELTA_BITS    = 16;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned ALPHA_BITS    = FRAC_BITS + 1;
  localparam int unsigned OPACITY_BITS  = 8;
  localparam int unsigned SCALE_BITS    = ALPHA_BITS + OPACITY_BITS;
  localparam int unsigned BOUND_BITS    = DURATION_BITS + 2;
  localparam int unsigned CMP_BITS      = (ELAPSED_BITS > BOUND_BITS) ? ELAPSED_BITS : BOUND_BITS;
  localparam int unsigned CNT_BITS      = $clog2(FRAC_BITS);
  localparam int unsigned CFG_IDX_BITS  = 3;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DELAY_LEN = 3'd0,
    CFG_RISE_LEN  = 3'd1,
    CFG_HOLD_LEN  = 3'd2,
    CFG_FALL_LEN  = 3'd3,
    CFG_ONCE_ONLY = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_SQUARE,
    ST_EASE,
    ST_SCALE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/fade_envelope_sequencer_top.sv =====
// Opacity envelope: a start word (tuser 1) enables the envelope, each tick word (tuser 0)
// adds, while enabled, its tdata delta to a saturating elapsed counter and returns one word
// holding the opacity byte in tdata and the enabled flag in tuser. Phases run delay (0),
// eased rise, hold (255), eased fall, then done (0, envelope disables itself). A start word,
// or a tick while disabled, goes STEP then EMIT; a tick in delay, hold or done goes through
// STEP, SCALE and EMIT; a tick in a ramp through STEP, the 16-step restoring divider that
// forms the normalized ramp time one quotient bit per cycle, then SQUARE, EASE, SCALE, EMIT.
// One word is worked on at a time; the result sits in an output register so the next word
// is taken while it waits. Configuration writes are always ready and apply from the next tick.
`default_nettype none

module fade_envelope_sequencer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fes_pkg::DELTA_BITS-1:0]      s_axis_tdata,  // tick_delta
  input  logic                                s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fes_pkg::OPACITY_BITS-1:0]    m_axis_tdata,  // opacity
  output logic                                m_axis_tuser,  // active
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fes_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [fes_pkg::DURATION_BITS-1:0]   cfg_data_i
);

  localparam int unsigned DB = fes_pkg::DURATION_BITS;
  localparam int unsigned EB = fes_pkg::ELAPSED_BITS;
  localparam int unsigned FB = fes_pkg::FRAC_BITS;
  localparam int unsigned AB = fes_pkg::ALPHA_BITS;
  localparam int unsigned OB = fes_pkg::OPACITY_BITS;
  localparam int unsigned SB = fes_pkg::SCALE_BITS;
  localparam int unsigned BB = fes_pkg::BOUND_BITS;
  localparam int unsigned CB = fes_pkg::CMP_BITS;
  localparam int unsigned NB = fes_pkg::CNT_BITS;
  localparam logic [AB-1:0] AlphaOne = AB'(1) << FB;

  // configuration
  logic [DB-1:0] delay_q, rise_q, hold_q, fall_q;
  logic          once_q;

  // control state
  fes_pkg::state_e state_q, state_d;
  logic [EB-1:0]   elapsed_q, elapsed_d;
  logic            running_q, running_d;
  logic [OB-1:0]   held_q, held_d;
  logic            m_tvalid_q, m_tvalid_d;

  // datapath
  logic                 kind_q;
  logic [fes_pkg::DELTA_BITS-1:0] delta_q;
  logic [DB-1:0]        rem_q, rem_d;
  logic [DB-1:0]        len_q, len_d;
  logic [FB-1:0]        quot_q, quot_d;
  logic [NB-1:0]        cnt_q, cnt_d;
  logic                 falling_q, falling_d;
  logic [2*FB-1:0]      prod_q, prod_d;
  logic [AB-1:0]        alpha_q, alpha_d;
  logic [OB-1:0]        m_tdata_q, m_tdata_d;
  logic                 m_tuser_q, m_tuser_d;

  logic [EB:0]   e_sum;
  logic [EB-1:0] e_sat;
  logic [BB-1:0] b1, b2, b3, b4;
  logic [CB-1:0] e_cmp, ramp_base, since;
  logic          in_rise;
  logic [DB:0]   rem_sh;
  logic [DB+1:0] diff;
  logic          ge;
  logic [FB:0]   sq_wide;
  logic [FB-1:0] sq_op;
  logic [AB-1:0] sq_scaled, ease;
  logic [SB-1:0] scaled;

  assign s_axis_tready = (state_q == fes_pkg::ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    e_sum     = (EB+1)'(elapsed_q) + (EB+1)'(delta_q);
    e_sat     = e_sum[EB] ? {EB{1'b1}} : e_sum[EB-1:0];
    b1        = BB'(delay_q);
    b2        = b1 + BB'(rise_q);
    b3        = b2 + BB'(hold_q);
    b4        = b3 + BB'(fall_q);
    e_cmp     = CB'(e_sat);
    in_rise   = e_cmp < CB'(b2);
    ramp_base = in_rise ? CB'(b1) : CB'(b3);
    since     = e_cmp - ramp_base;
    // compare and subtract of the restoring divider, reused by every DIV step
    rem_sh    = {rem_q, 1'b0};
    diff      = {1'b0, rem_sh} - (DB+2)'(len_q);
    ge        = !diff[DB+1];
    sq_wide   = (FB+1)'(AlphaOne) - (FB+1)'(quot_q);
    sq_op     = quot_q[FB-1] ? sq_wide[FB-1:0] : quot_q;
    sq_scaled = prod_q[2*FB-1:FB-1];
    ease      = quot_q[FB-1] ? (AlphaOne - sq_scaled) : sq_scaled;
    scaled    = (SB'(alpha_q) << OB) - SB'(alpha_q);
  end

  always_comb begin
    state_d    = state_q;
    elapsed_d  = elapsed_q;
    running_d  = running_q;
    held_d     = held_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    rem_d      = rem_q;
    len_d      = len_q;
    quot_d     = quot_q;
    cnt_d      = cnt_q;
    falling_d  = falling_q;
    prod_d     = prod_q;
    alpha_d    = alpha_q;
    case (state_q)
      fes_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = fes_pkg::ST_STEP;
        end
      end
      fes_pkg::ST_STEP: begin
        if (kind_q == fes_pkg::KIND_START) begin
          running_d = 1'b1;
          state_d   = fes_pkg::ST_EMIT;
        end else if (!running_q) begin
          state_d = fes_pkg::ST_EMIT;
        end else begin
          elapsed_d = e_sat;
          state_d   = fes_pkg::ST_SCALE;
          rem_d     = since[DB-1:0];
          cnt_d     = '0;
          quot_d    = '0;
          if (e_cmp < CB'(b1)) begin
            alpha_d = '0;
          end else if (in_rise) begin
            len_d     = rise_q;
            falling_d = 1'b0;
            state_d   = fes_pkg::ST_DIV;
          end else if (e_cmp < CB'(b3)) begin
            alpha_d = AlphaOne;
          end else if (e_cmp < CB'(b4)) begin
            len_d     = fall_q;
            falling_d = 1'b1;
            state_d   = fes_pkg::ST_DIV;
          end else begin
            alpha_d   = '0;
            running_d = 1'b0;
            if (!once_q) begin
              elapsed_d = '0;
            end
          end
        end
      end
      fes_pkg::ST_DIV: begin
        rem_d  = ge ? diff[DB-1:0] : rem_sh[DB-1:0];
        quot_d = {quot_q[FB-2:0], ge};
        cnt_d  = cnt_q + NB'(1);
        if (cnt_q == NB'(FB - 1)) begin
          state_d = fes_pkg::ST_SQUARE;
        end
      end
      fes_pkg::ST_SQUARE: begin
        prod_d  = (2*FB)'(sq_op) * (2*FB)'(sq_op);
        state_d = fes_pkg::ST_EASE;
      end
      fes_pkg::ST_EASE: begin
        alpha_d = falling_q ? (AlphaOne - ease) : ease;
        state_d = fes_pkg::ST_SCALE;
      end
      fes_pkg::ST_SCALE: begin
        held_d  = scaled[FB +: OB];
        state_d = fes_pkg::ST_EMIT;
      end
      fes_pkg::ST_EMIT: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = held_q;
          m_tuser_d  = running_q;
          state_d    = fes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fes_pkg::ST_IDLE;
      elapsed_q  <= '0;
      running_q  <= 1'b0;
      held_q     <= '0;
      m_tvalid_q <= 1'b0;
      delay_q    <= '0;
      rise_q     <= '0;
      hold_q     <= '0;
      fall_q     <= '0;
      once_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      elapsed_q  <= elapsed_d;
      running_q  <= running_d;
      held_q     <= held_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_valid_i) begin
        case (fes_pkg::cfg_idx_e'(cfg_index_i))
          fes_pkg::CFG_DELAY_LEN: delay_q <= cfg_data_i;
          fes_pkg::CFG_RISE_LEN:  rise_q  <= cfg_data_i;
          fes_pkg::CFG_HOLD_LEN:  hold_q  <= cfg_data_i;
          fes_pkg::CFG_FALL_LEN:  fall_q  <= cfg_data_i;
          fes_pkg::CFG_ONCE_ONLY: once_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tuser;
      delta_q <= s_axis_tdata;
    end
    rem_q     <= rem_d;
    len_q     <= len_d;
    quot_q    <= quot_d;
    cnt_q     <= cnt_d;
    falling_q <= falling_d;
    prod_q    <= prod_d;
    alpha_q   <= alpha_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

endmodule

`default_nettype wire

// ===== hdl/fes_checker.sv =====
`default_nettype none
`include "fade_envelope_sequencer_top_defines.svh"

module fes_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [fes_pkg::OPACITY_BITS-1:0]    m_axis_tdata,
  input logic                                m_axis_tuser
);

  // one word in flight at a time
  `FES_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a new result appears together with the input side opening again
  `FES_ASSERT_NOW(a_result_reopens_input, $rose(m_axis_tvalid), s_axis_tready)

  // stalled result word holds
  `FES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind fade_envelope_sequencer_top fes_checker u_fes_checker (.*);

`default_nettype wire
